// ===== rtl/core/ptl_pkg.sv =====
package ptl_pkg;

   // fixed field widths of the channels
   localparam int LA_W      = 17;
   localparam int PA_W      = 15;
   localparam int OUTCOME_W = 2;

   // default sizes
   localparam int PAGE_COUNT_DEF  = 32;
   localparam int FRAME_COUNT_DEF = 8;
   localparam int OFFSET_BITS_DEF = 12;

   typedef enum logic [OUTCOME_W-1:0] {
      OUTCOME_HIT   = 2'd0,
      OUTCOME_FILL  = 2'd1,
      OUTCOME_EVICT = 2'd2
   } outcome_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;       // take request, start reduction or table read
      logic reduce_step;   // one remainder step
      logic read_reduced;  // read page table at the reduced index
      logic commit;        // update tables, load response
      logic invalidate;    // clear the evicted page's entry
      logic clear_step;    // post-reset sweep of the page table
   } ptl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic direct_index;
      logic reduce_done;
      logic clear_last;
      logic evict;
      logic out_free;
   } ptl_status_type;

endpackage

// ===== rtl/core/ptl_if.sv =====
interface ptl_req_if import ptl_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [LA_W-1:0] logical_address;

   modport source (output valid, output logical_address, input ready);
   modport sink (input valid, input logical_address, output ready);
endinterface

interface ptl_rsp_if import ptl_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PA_W-1:0]      physical_address;
   logic [OUTCOME_W-1:0] outcome;

   modport source (output valid, output physical_address, output outcome, input ready);
   modport sink (input valid, input physical_address, input outcome, output ready);
endinterface

// ===== rtl/core/ptl_ctrl.sv =====
module ptl_ctrl import ptl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  ptl_status_type status,
   output ptl_cmd_type    cmd,
   output logic           req_ready
);

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_REDUCE = 5'b00100,
      ST_LOOKUP = 5'b01000,
      ST_INVAL  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.direct_index ? ST_LOOKUP : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (status.reduce_done) begin
               cmd.read_reduced = 1'b1;
               state_in         = ST_LOOKUP;
            end else begin
               cmd.reduce_step = 1'b1;
            end
         end
         ST_LOOKUP: begin
            // hold until the response register can take the result
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = status.evict ? ST_INVAL : ST_IDLE;
            end
         end
         ST_INVAL: begin
            cmd.invalidate = 1'b1;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   a_inval_after_lookup: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INVAL |-> $past(state_ff == ST_LOOKUP))
      else $error("invalidate not preceded by a lookup commit");

endmodule

// ===== rtl/core/ptl_datapath.sv =====
module ptl_datapath import ptl_pkg::*; #(
   parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
   parameter int FRAME_COUNT = FRAME_COUNT_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ptl_cmd_type          cmd,
   output ptl_status_type       status,
   input  logic [LA_W-1:0]      req_logical_address,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [PA_W-1:0]      rsp_physical_address,
   output logic [OUTCOME_W-1:0] rsp_outcome
);

   localparam int PW        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int FW        = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int RAW_W     = LA_W - OFFSET_BITS;
   localparam int ENTRY_W   = FW + 1;
   localparam bit PAGE_POW2 = (PAGE_COUNT & (PAGE_COUNT - 1)) == 0;
   localparam logic [FW-1:0] RANK_MAX = FW'(FRAME_COUNT - 1);

   // page table entry: {valid, frame}
   logic [ENTRY_W-1:0]     page_table_mem [PAGE_COUNT];
   logic [PW-1:0]          owner_mem [FRAME_COUNT];

   logic [ENTRY_W-1:0]     pt_rd_ff;
   logic [PW-1:0]          owner_rd_ff;
   logic [PW-1:0]          page_idx_ff, page_idx_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [PW-1:0]          clr_cnt_ff, clr_cnt_in;
   logic [FRAME_COUNT-1:0] frame_free_ff, frame_free_in;
   logic [FW-1:0]          rank_ff [FRAME_COUNT];
   logic [FW-1:0]          rank_in [FRAME_COUNT];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PA_W-1:0]        rsp_pa_ff, rsp_pa_in;
   logic [OUTCOME_W-1:0]   rsp_outcome_ff, rsp_outcome_in;

   logic [RAW_W-1:0]       raw_page;
   logic [PW-1:0]          direct_idx, reduced_idx, rd_addr;
   logic                   rd_en, reduce_done;
   logic                   hit, free_any, newly, out_free;
   logic [FW-1:0]          free_idx, victim_idx, f_sel, old_rank;
   outcome_type            outcome_sel;
   logic                   pt_we;
   logic [PW-1:0]          pt_waddr;
   logic [ENTRY_W-1:0]     pt_wdata;
   logic [FW+OFFSET_BITS-1:0] pa_full;

   // ---- page index ----
   assign raw_page   = RAW_W'(req_logical_address >> OFFSET_BITS);
   assign direct_idx = PW'(raw_page);

   generate
      if (PAGE_POW2) begin : g_direct
         assign reduced_idx = '0;
         assign reduce_done = 1'b1;
      end else begin : g_reduce
         // remainder by the constant page count: reciprocal estimate of the
         // quotient (never high, at most one low), then one compare and subtract
         localparam int SH = RAW_W + PW;
         localparam int QW = RAW_W + SH;
         localparam int DW = RAW_W + PW + 1;
         localparam logic [SH-1:0] RECIP = SH'((64'd1 << SH) / PAGE_COUNT);
         logic [RAW_W-1:0] raw_ff, raw_in;
         logic [RAW_W-1:0] quo_ff, quo_in;
         logic [PW-1:0]    rem_ff, rem_in;
         logic [1:0]       cnt_ff, cnt_in;
         logic [QW-1:0]    prod;
         logic [DW-1:0]    part;

         always_comb begin
            prod = QW'(raw_ff) * QW'(RECIP);
            part = DW'(raw_ff) - DW'(quo_ff) * DW'(PAGE_COUNT);
            if (part >= DW'(PAGE_COUNT)) part = part - DW'(PAGE_COUNT);
            raw_in = raw_ff;
            quo_in = quo_ff;
            rem_in = rem_ff;
            cnt_in = cnt_ff;
            if (cmd.capture) begin
               raw_in = raw_page;
               cnt_in = 2'd2;
            end else if (cmd.reduce_step && cnt_ff != '0) begin
               if (cnt_ff == 2'd2) quo_in = RAW_W'(prod >> SH);
               else                rem_in = PW'(part);
               cnt_in = cnt_ff - 2'd1;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) cnt_ff <= '0;
            else       cnt_ff <= cnt_in;
         end

         always_ff @(posedge clock) begin
            raw_ff <= raw_in;
            quo_ff <= quo_in;
            rem_ff <= rem_in;
         end

         assign reduced_idx = rem_ff;
         assign reduce_done = (cnt_ff == '0);
      end
   endgenerate

   always_comb begin
      rd_en       = (cmd.capture && PAGE_POW2) || cmd.read_reduced;
      rd_addr     = cmd.read_reduced ? reduced_idx : direct_idx;
      page_idx_in = rd_en ? rd_addr : page_idx_ff;
      offset_in   = cmd.capture ? req_logical_address[OFFSET_BITS-1:0] : offset_ff;
   end

   // ---- frame selection ----
   always_comb begin
      free_any   = |frame_free_ff;
      free_idx   = '0;
      victim_idx = '0;
      for (int g = FRAME_COUNT - 1; g >= 0; g--) begin
         if (frame_free_ff[g])    free_idx   = FW'(g);
         if (rank_ff[g] == RANK_MAX) victim_idx = FW'(g);
      end
   end

   always_comb begin
      hit   = pt_rd_ff[FW];
      newly = !hit && free_any;
      if (hit) begin
         f_sel       = pt_rd_ff[FW-1:0];
         outcome_sel = OUTCOME_HIT;
      end else if (free_any) begin
         f_sel       = free_idx;
         outcome_sel = OUTCOME_FILL;
      end else begin
         f_sel       = victim_idx;
         outcome_sel = OUTCOME_EVICT;
      end
      old_rank = rank_ff[f_sel];
   end

   // LRU ranks: chosen frame to 0, younger (or all, on a fill) occupied frames age by one, saturating at RANK_MAX
   always_comb begin
      frame_free_in = frame_free_ff;
      if (cmd.commit && !hit) frame_free_in[f_sel] = 1'b0;
      for (int g = 0; g < FRAME_COUNT; g++) begin
         rank_in[g] = rank_ff[g];
         if (cmd.commit) begin
            if (FW'(g) == f_sel) begin
               rank_in[g] = '0;
            end else if (!frame_free_ff[g] && (newly || rank_ff[g] < old_rank)
                         && rank_ff[g] != RANK_MAX) begin
               rank_in[g] = rank_ff[g] + FW'(1);
            end
         end
      end
   end

   // ---- page table write port ----
   always_comb begin
      pt_we    = 1'b0;
      pt_waddr = page_idx_ff;
      pt_wdata = '0;
      priority if (cmd.clear_step) begin
         pt_we    = 1'b1;
         pt_waddr = clr_cnt_ff;
      end else if (cmd.commit && !hit) begin
         pt_we    = 1'b1;
         pt_wdata = {1'b1, f_sel};
      end else if (cmd.invalidate) begin
         pt_we    = 1'b1;
         pt_waddr = owner_rd_ff;
      end
   end

   assign clr_cnt_in = cmd.clear_step ? clr_cnt_ff + PW'(1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (pt_we) page_table_mem[pt_waddr] <= pt_wdata;
      if (rd_en) pt_rd_ff <= page_table_mem[rd_addr];
   end

   // owner read sees the value before this commit's write
   always_ff @(posedge clock) begin
      if (cmd.commit && !hit) owner_mem[f_sel] <= page_idx_ff;
      if (cmd.commit)         owner_rd_ff <= owner_mem[victim_idx];
   end

   // ---- response register ----
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pa_full  = {f_sel, offset_ff};

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_pa_in      = rsp_pa_ff;
      rsp_outcome_in = rsp_outcome_ff;
      if (cmd.commit) begin
         rsp_valid_in   = 1'b1;
         rsp_pa_in      = PA_W'(pa_full);
         rsp_outcome_in = outcome_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         clr_cnt_ff    <= '0;
         frame_free_ff <= '1;
         for (int g = 0; g < FRAME_COUNT; g++) rank_ff[g] <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         clr_cnt_ff    <= clr_cnt_in;
         frame_free_ff <= frame_free_in;
         for (int g = 0; g < FRAME_COUNT; g++) rank_ff[g] <= rank_in[g];
      end
   end

   always_ff @(posedge clock) begin
      page_idx_ff    <= page_idx_in;
      offset_ff      <= offset_in;
      rsp_pa_ff      <= rsp_pa_in;
      rsp_outcome_ff <= rsp_outcome_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_pa_ff;
   assign rsp_outcome          = rsp_outcome_ff;

   always_comb begin
      status.direct_index = PAGE_POW2;
      status.reduce_done  = reduce_done;
      status.clear_last   = (clr_cnt_ff == PW'(PAGE_COUNT - 1));
      status.evict        = !hit && !free_any;
      status.out_free     = out_free;
   end

   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> out_free)
      else $error("commit while response register still occupied");

   a_chosen_newest: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rank_ff[$past(f_sel)] == '0)
      else $error("chosen frame not made most recently used");

   a_victim_not_new: assert property (@(posedge clock) disable iff (reset)
      cmd.invalidate |-> owner_rd_ff != page_idx_ff)
      else $error("eviction would invalidate the page just filled");

endmodule

// ===== rtl/core/page_translate_lru_top.sv =====
// The result is registered in LOOKUP, after the request transaction is taken in IDLE
//   and, when PAGE_COUNT is not a power of two, after REDUCE (page index reduction).
// A request transaction is taken only in IDLE, after the last leaves LOOKUP and,
//   on an eviction, INVAL (the single page table write port drops the victim page).
// Reset: synchronous, active high; then CLEAR sweeps the page table valid bits clear,
//   during which no request transaction is taken.
module page_translate_lru_top import ptl_pkg::*; #(
   parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
   parameter int FRAME_COUNT = FRAME_COUNT_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   ptl_req_if.sink   req_chan,
   ptl_rsp_if.source rsp_chan
);

   // controller sequences CLEAR -> IDLE -> (REDUCE) -> LOOKUP -> (INVAL);
   // the datapath holds the tables, LRU ranks and the response register.
   ptl_cmd_type    cmd;
   ptl_status_type status;
   logic           req_ready;

   assign req_chan.ready = req_ready;

   ptl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   // page table read issues as the request is taken, or after REDUCE if PAGE_COUNT
   // is not a power of two; update and response load wait in LOOKUP until out_free.
   ptl_datapath #(
      .PAGE_COUNT  (PAGE_COUNT),
      .FRAME_COUNT (FRAME_COUNT),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_logical_address  (req_chan.logical_address),
      .rsp_ready            (rsp_chan.ready),
      .rsp_valid            (rsp_chan.valid),
      .rsp_physical_address (rsp_chan.physical_address),
      .rsp_outcome          (rsp_chan.outcome)
   );

endmodule
